// ----- src/seconds_counter_calendar_alarm_top_macros.svh -----
// assertion helpers used by rtcca_ctrl
`ifndef SECONDS_COUNTER_CALENDAR_ALARM_TOP_MACROS_SVH
`define SECONDS_COUNTER_CALENDAR_ALARM_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define RTCCA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RTCCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/rtcca_pkg.sv -----
package rtcca_pkg;

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_READ     = 3'd1;
  localparam logic [2:0] REQ_SET_TIME = 3'd2;
  localparam logic [2:0] REQ_SET_DATE = 3'd3;
  localparam logic [2:0] REQ_CLEAR    = 3'd4;

  localparam logic [1:0] REG_TWELVE_HOUR  = 2'd0;
  localparam logic [1:0] REG_ALARM_ENABLE = 2'd1;
  localparam logic [1:0] REG_ALARM_HOUR   = 2'd2;
  localparam logic [1:0] REG_ALARM_MINUTE = 2'd3;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  // floor(2^32 / divisor) for each constant divisor
  localparam logic [31:0] RECIP_DAY  = 32'(64'd4294967296 / 64'd86400);
  localparam logic [31:0] RECIP_HOUR = 32'(64'd4294967296 / 64'd3600);
  localparam logic [31:0] RECIP_MIN  = 32'(64'd4294967296 / 64'd60);
  localparam logic [31:0] RECIP_1460 = 32'(64'd4294967296 / 64'd1460);
  localparam logic [31:0] RECIP_365  = 32'(64'd4294967296 / 64'd365);
  localparam logic [31:0] RECIP_7    = 32'(64'd4294967296 / 64'd7);

  // day count is kept relative to 1600-03-01, start of a 400-year cycle
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [17:0] ERA_OFFSET   = 18'd146037;
  localparam logic [17:0] LAST_DOE     = 18'd146096;
  localparam logic [11:0] BASE_YEAR    = 12'd1600;

  typedef enum logic [2:0] {
    DIV_DAYS,
    DIV_HOUR,
    DIV_MIN,
    DIV_Q1460,
    DIV_YEAR,
    DIV_WDAY
  } div_op_t;

  typedef struct packed {
    logic    load;
    logic    div_start;
    div_op_t div_sel;
    logic    dd_calc;
    logic    mul;
    logic    upd;
    logic    doy_calc;
    logic    fin;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       div_busy;
    logic       div_done;
  } dp_sts_t;

  typedef struct packed {
    logic       twelve_hour_mode;
    logic       alarm_enable;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
    logic [31:0] recip;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
    logic [16:0] rem;
  } div_rsp_t;

  // first day of year of each month, march-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/seconds_counter_calendar_alarm_top.sv -----
// Seconds counter with a UTC calendar view and a sticky hour/minute alarm. Each transaction on
// the slave stream (s_tuser: 0 tick, 1 read, 2 set time, 3 set date, 4 clear alarm, others
// read) yields exactly one result transaction on the master stream with year, month, day,
// weekday, hour, minute, second, PM mark, alarm flag and raw count after the request. One item
// is handled at a time: the next input is taken only once the last result has been accepted.
// The view is built by six passes through a shared constant divider (reciprocal multiply,
// remainder, one correction step) for day split, hour, minute, two calendar divisions and
// weekday; a set time or set date first splits the old count there too. Registers on the APB
// port should be written only while the block is idle.
module seconds_counter_calendar_alarm_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // set_hour, set_minute, set_second, set_year, set_month, set_day
  input  logic [39:0] s_tdata,
  // req_type
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // full_year, month, day, weekday, shown_hour, minute, second, is_pm, alarm_fired,
  // seconds_count
  output logic [79:0] m_tdata
);

  rtcca_pkg::cfg_t    cfg;
  rtcca_pkg::dp_cmd_t cmd;
  rtcca_pkg::dp_sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        rtcca_pkg::REG_TWELVE_HOUR:  cfg.twelve_hour_mode <= pwdata[0];
        rtcca_pkg::REG_ALARM_ENABLE: cfg.alarm_enable <= pwdata[0];
        rtcca_pkg::REG_ALARM_HOUR:   cfg.alarm_hour <= pwdata[4:0];
        rtcca_pkg::REG_ALARM_MINUTE: cfg.alarm_minute <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rtcca_pkg::REG_TWELVE_HOUR:  prdata = {31'd0, cfg.twelve_hour_mode};
      rtcca_pkg::REG_ALARM_ENABLE: prdata = {31'd0, cfg.alarm_enable};
      rtcca_pkg::REG_ALARM_HOUR:   prdata = {27'd0, cfg.alarm_hour};
      rtcca_pkg::REG_ALARM_MINUTE: prdata = {26'd0, cfg.alarm_minute};
      default:                     prdata = 32'd0;
    endcase
  end

  rtcca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rtcca_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .in_tdata  (s_tdata),
    .in_tuser  (s_tuser),
    .out_tdata (m_tdata)
  );

endmodule

// ----- src/rtcca_div.sv -----
module rtcca_div (
  input  logic                clk,
  input  logic                rst,
  input  rtcca_pkg::div_req_t req,
  output rtcca_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [1:0]  step;
  logic [31:0] dvd;
  logic [16:0] divisor;
  logic [31:0] recip;
  logic [63:0] prod;
  logic [31:0] q_est;
  logic [31:0] r_est;
  logic [31:0] quo;
  logic [16:0] rem;

  // recip is floor(2^32 / divisor), so the estimate is low by at most one
  assign prod = 64'(dvd) * 64'(recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // reciprocal estimate, remainder, one correction step
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= req.dividend;
      divisor <= req.divisor;
      recip   <= req.recip;
    end else if (busy) begin
      case (step)
        2'd0: q_est <= prod[63:32];
        2'd1: r_est <= dvd - q_est * 32'(divisor);
        default: begin
          if (r_est >= 32'(divisor)) begin
            quo <= q_est + 32'd1;
            rem <= 17'(r_est - 32'(divisor));
          end else begin
            quo <= q_est;
            rem <= r_est[16:0];
          end
        end
      endcase
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

// ----- src/rtcca_dp.sv -----
module rtcca_dp (
  input  logic               clk,
  input  logic               rst,
  input  rtcca_pkg::dp_cmd_t cmd,
  output rtcca_pkg::dp_sts_t sts,
  input  rtcca_pkg::cfg_t    cfg,
  input  logic [39:0]        in_tdata,
  input  logic [2:0]         in_tuser,
  output logic [79:0]        out_tdata
);

  logic [2:0]  req_r;
  logic [4:0]  set_hour_r;
  logic [5:0]  set_minute_r;
  logic [5:0]  set_second_r;
  logic [6:0]  set_year_r;
  logic [3:0]  set_month_r;
  logic [4:0]  set_day_r;

  logic [31:0] count;
  logic        flag;
  logic        flag_next;

  logic [15:0] days_r;
  logic [16:0] tod_r;
  logic [4:0]  hour_r;
  logic [11:0] r3600;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [6:0]  q1460;
  logic [8:0]  yoe_r;
  logic [2:0]  wday_r;
  logic [8:0]  doy_r;
  logic [17:0] doe_r;
  logic        era_r;

  logic signed [19:0] dd_r;
  logic signed [19:0] dd_next;
  logic [31:0] prod_r;
  logic signed [19:0] mul_a;
  logic signed [37:0] mprod;
  logic [16:0] hms;

  logic [3:0]  mo;
  logic [3:0]  mpd;
  logic [9:0]  ya;
  logic [2:0]  y100;
  logic [19:0] pos;
  logic [19:0] neg;

  logic [17:0] z;
  logic        era;
  logic [17:0] doe;
  logic [2:0]  c36524;
  logic [17:0] xdiv;
  logic [1:0]  yq100;
  logic [17:0] doy_full;

  logic [3:0]  mp;
  logic [4:0]  dom;
  logic [3:0]  mon;
  logic [11:0] year;
  logic        pm;
  logic [4:0]  hs;
  logic        hit;

  rtcca_pkg::div_req_t divq;
  rtcca_pkg::div_rsp_t divs;

  rtcca_div u_div (
    .clk (clk),
    .rst (rst),
    .req (divq),
    .rsp (divs)
  );

  assign sts.req      = req_r;
  assign sts.div_busy = divs.busy;
  assign sts.div_done = divs.done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r        <= in_tuser;
      set_hour_r   <= in_tdata[4:0];
      set_minute_r <= in_tdata[10:5];
      set_second_r <= in_tdata[16:11];
      set_year_r   <= in_tdata[23:17];
      set_month_r  <= in_tdata[27:24];
      set_day_r    <= in_tdata[32:28];
    end
  end

  // days since 2000-01-01 of the requested date, may be negative
  always_comb begin
    mo = set_month_r;
    ya = 10'd400 + 10'(set_year_r);
    if (mo == 4'd0) begin
      mo = 4'd12;
      ya = ya - 10'd1;
    end else if (mo > 4'd12) begin
      mo = mo - 4'd12;
      ya = ya + 10'd1;
    end
    if (mo <= 4'd2) begin
      ya  = ya - 10'd1;
      mpd = mo + 4'd9;
    end else begin
      mpd = mo - 4'd3;
    end
    if (ya >= 10'd500)      y100 = 3'd5;
    else if (ya >= 10'd400) y100 = 3'd4;
    else if (ya >= 10'd300) y100 = 3'd3;
    else if (ya >= 10'd200) y100 = 3'd2;
    else if (ya >= 10'd100) y100 = 3'd1;
    else                    y100 = 3'd0;
    pos = 20'(ya) * 20'd365 + 20'(ya[9:2]) + 20'(ya >= 10'd400)
          + 20'(rtcca_pkg::month_start(mpd)) + 20'(set_day_r);
    neg = 20'(y100) + 20'd1 + 20'(rtcca_pkg::ERA_OFFSET);
    dd_next = $signed(pos - neg);
  end

  assign hms = 17'(set_hour_r) * rtcca_pkg::SECS_PER_HOUR
             + 17'(set_minute_r) * rtcca_pkg::SECS_PER_MIN + 17'(set_second_r);

  assign mul_a = (req_r == rtcca_pkg::REQ_SET_TIME) ? $signed({4'd0, days_r}) : dd_r;
  assign mprod = 38'(mul_a) * 38'($signed({1'b0, rtcca_pkg::SECS_PER_DAY}));

  always_ff @(posedge clk) begin
    if (cmd.dd_calc) dd_r <= dd_next;
    if (cmd.mul)     prod_r <= mprod[31:0];
  end

  // position inside the 400-year cycle
  assign z   = 18'(days_r) + rtcca_pkg::ERA_OFFSET;
  assign era = z >= rtcca_pkg::DAYS_PER_ERA;
  assign doe = era ? z - rtcca_pkg::DAYS_PER_ERA : z;

  always_ff @(posedge clk) begin
    doe_r <= doe;
    era_r <= era;
  end

  always_comb begin
    if (doe_r >= 18'd146096)     c36524 = 3'd4;
    else if (doe_r >= 18'd109572) c36524 = 3'd3;
    else if (doe_r >= 18'd73048)  c36524 = 3'd2;
    else if (doe_r >= 18'd36524)  c36524 = 3'd1;
    else                          c36524 = 3'd0;
    xdiv = doe_r - 18'(q1460) + 18'(c36524) - 18'(doe_r == rtcca_pkg::LAST_DOE);
    if (yoe_r >= 9'd300)      yq100 = 2'd3;
    else if (yoe_r >= 9'd200) yq100 = 2'd2;
    else if (yoe_r >= 9'd100) yq100 = 2'd1;
    else                      yq100 = 2'd0;
    doy_full = doe_r - 18'(yoe_r) * 18'd365 - 18'(yoe_r[8:2]) + 18'(yq100);
  end

  always_comb begin
    divq.start = cmd.div_start;
    case (cmd.div_sel)
      rtcca_pkg::DIV_HOUR: begin
        divq.dividend = 32'(tod_r);
        divq.divisor  = rtcca_pkg::SECS_PER_HOUR;
        divq.recip    = rtcca_pkg::RECIP_HOUR;
      end
      rtcca_pkg::DIV_MIN: begin
        divq.dividend = 32'(r3600);
        divq.divisor  = rtcca_pkg::SECS_PER_MIN;
        divq.recip    = rtcca_pkg::RECIP_MIN;
      end
      rtcca_pkg::DIV_Q1460: begin
        divq.dividend = 32'(doe_r);
        divq.divisor  = 17'd1460;
        divq.recip    = rtcca_pkg::RECIP_1460;
      end
      rtcca_pkg::DIV_YEAR: begin
        divq.dividend = 32'(xdiv);
        divq.divisor  = 17'd365;
        divq.recip    = rtcca_pkg::RECIP_365;
      end
      rtcca_pkg::DIV_WDAY: begin
        divq.dividend = 32'(days_r) + 32'd6;
        divq.divisor  = 17'd7;
        divq.recip    = rtcca_pkg::RECIP_7;
      end
      default: begin
        divq.dividend = count;
        divq.divisor  = rtcca_pkg::SECS_PER_DAY;
        divq.recip    = rtcca_pkg::RECIP_DAY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (divs.done) begin
      case (cmd.div_sel)
        rtcca_pkg::DIV_HOUR: begin
          hour_r <= divs.quo[4:0];
          r3600  <= divs.rem[11:0];
        end
        rtcca_pkg::DIV_MIN: begin
          min_r <= divs.quo[5:0];
          sec_r <= divs.rem[5:0];
        end
        rtcca_pkg::DIV_Q1460: q1460 <= divs.quo[6:0];
        rtcca_pkg::DIV_YEAR:  yoe_r <= divs.quo[8:0];
        rtcca_pkg::DIV_WDAY:  wday_r <= divs.rem[2:0];
        default: begin
          days_r <= divs.quo[15:0];
          tod_r  <= divs.rem;
        end
      endcase
    end
    if (cmd.doy_calc) doy_r <= doy_full[8:0];
  end

  // calendar view and alarm of the new count
  always_comb begin
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy_r >= rtcca_pkg::month_start(4'(k))) mp = 4'(k);
    end
    dom  = 5'(doy_r - rtcca_pkg::month_start(mp) + 9'd1);
    mon  = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    year = rtcca_pkg::BASE_YEAR + (era_r ? 12'd400 : 12'd0) + 12'(yoe_r)
         + 12'(mon <= 4'd2);
    if (cfg.twelve_hour_mode) begin
      pm = hour_r >= 5'd12;
      if (hour_r == 5'd0)       hs = 5'd12;
      else if (hour_r > 5'd12)  hs = hour_r - 5'd12;
      else                      hs = hour_r;
    end else begin
      pm = 1'b0;
      hs = hour_r;
    end
    hit = cfg.alarm_enable && hour_r == cfg.alarm_hour && min_r == cfg.alarm_minute
          && sec_r == 6'd0;
    flag_next = flag | (hit && req_r != rtcca_pkg::REQ_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 32'd0;
      flag  <= 1'b0;
    end else begin
      if (cmd.upd) begin
        case (req_r)
          rtcca_pkg::REQ_TICK:     count <= count + 32'd1;
          rtcca_pkg::REQ_SET_TIME: count <= prod_r + 32'(hms);
          rtcca_pkg::REQ_SET_DATE: count <= prod_r + 32'(tod_r);
          rtcca_pkg::REQ_CLEAR:    flag <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.fin) flag <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_tdata <= {5'd0, count, flag_next, pm, sec_r, min_r, hs, wday_r, dom, mon, year};
    end
  end

endmodule

// ----- src/rtcca_ctrl.sv -----
`include "seconds_counter_calendar_alarm_top_macros.svh"

module rtcca_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output rtcca_pkg::dp_cmd_t cmd,
  input  rtcca_pkg::dp_sts_t sts
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_DISP  = 15'b000000000000010,
    S_OLD   = 15'b000000000000100,
    S_DDAY  = 15'b000000000001000,
    S_MUL   = 15'b000000000010000,
    S_UPD   = 15'b000000000100000,
    S_DAYS  = 15'b000000001000000,
    S_HOUR  = 15'b000000010000000,
    S_MIN   = 15'b000000100000000,
    S_Q1460 = 15'b000001000000000,
    S_YEAR  = 15'b000010000000000,
    S_DOY   = 15'b000100000000000,
    S_WDAY  = 15'b001000000000000,
    S_FIN   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   div_go;

  assign div_go = !sts.div_busy && !sts.div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = rtcca_pkg::DIV_DAYS;
    unique case (state)
      S_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid) state_next = S_DISP;
      end
      S_DISP: begin
        if (sts.req == rtcca_pkg::REQ_SET_TIME || sts.req == rtcca_pkg::REQ_SET_DATE) begin
          state_next = S_OLD;
        end else begin
          state_next = S_UPD;
        end
      end
      S_OLD: begin
        cmd.div_start = div_go;
        if (sts.div_done) begin
          state_next = (sts.req == rtcca_pkg::REQ_SET_DATE) ? S_DDAY : S_MUL;
        end
      end
      S_DDAY: begin
        cmd.dd_calc = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_DAYS;
      end
      S_DAYS: begin
        cmd.div_start = div_go;
        if (sts.div_done) state_next = S_HOUR;
      end
      S_HOUR: begin
        cmd.div_sel   = rtcca_pkg::DIV_HOUR;
        cmd.div_start = div_go;
        if (sts.div_done) state_next = S_MIN;
      end
      S_MIN: begin
        cmd.div_sel   = rtcca_pkg::DIV_MIN;
        cmd.div_start = div_go;
        if (sts.div_done) state_next = S_Q1460;
      end
      S_Q1460: begin
        cmd.div_sel   = rtcca_pkg::DIV_Q1460;
        cmd.div_start = div_go;
        if (sts.div_done) state_next = S_YEAR;
      end
      S_YEAR: begin
        cmd.div_sel   = rtcca_pkg::DIV_YEAR;
        cmd.div_start = div_go;
        if (sts.div_done) state_next = S_DOY;
      end
      S_DOY: begin
        cmd.doy_calc = 1'b1;
        state_next   = S_WDAY;
      end
      S_WDAY: begin
        cmd.div_sel   = rtcca_pkg::DIV_WDAY;
        cmd.div_start = div_go;
        if (sts.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);

  `RTCCA_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
  `RTCCA_ASSERT_NEXT(a_back_idle, m_tvalid && m_tready, s_tready, "no return to idle after result")
  `RTCCA_ASSERT_NEXT(a_div_runs, cmd.div_start, sts.div_busy, "divider did not start")
  `RTCCA_ASSERT_IMPLIES(a_done_owned, sts.div_done,
    state == S_OLD || state == S_DAYS || state == S_HOUR || state == S_MIN ||
    state == S_Q1460 || state == S_YEAR || state == S_WDAY, "divider result with no owner")

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int DAY_SECS = 86400;

  // packed from the top bit down, so full_year lands in the lowest bits
  typedef struct packed {
    logic [31:0] seconds_count;
    logic        alarm_fired;
    logic        is_pm;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  shown_hour;
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] full_year;
  } view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // set_hour, set_minute, set_second, set_year, set_month, set_day
  logic [39:0] s_tdata = '0;
  // req_type
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // full_year, month, day, weekday, shown_hour, minute, second, is_pm, alarm_fired,
  // seconds_count
  logic [79:0] m_tdata;

  // clock state mirrored by the predictor
  logic [31:0] clock_secs;
  logic        alarm_latched;
  logic        mode_12h, alm_en;
  logic [4:0]  alm_hour;
  logic [5:0]  alm_min;

  view_t expected_views[$];
  int    errors = 0;
  int    send_gap_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_off = 1'b0;
  int    quiet_cycles = 0;

  seconds_counter_calendar_alarm_top u_dut (.*);

  always #10 clk = ~clk;

  function automatic longint civil_days(longint y, longint m, longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y -= 1;
    era = y / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic view_t advance_clock(logic [2:0] req, logic [39:0] d);
    view_t v;
    longint t, yr, mon;
    logic [31:0] days, tod, z, era, doe, yoe, doy, mp, y, m, h;
    case (req)
      rtcca_pkg::REQ_TICK: clock_secs = clock_secs + 1;
      rtcca_pkg::REQ_SET_TIME: begin
        t = longint'(clock_secs / DAY_SECS) * DAY_SECS + longint'(d[4:0]) * 3600 +
            longint'(d[10:5]) * 60 + longint'(d[16:11]);
        clock_secs = t[31:0];
      end
      rtcca_pkg::REQ_SET_DATE: begin
        yr = 2000 + longint'(d[23:17]);
        mon = longint'(d[27:24]) - 1;
        if (mon < 0) begin
          mon += 12;
          yr -= 1;
        end else if (mon >= 12) begin
          mon -= 12;
          yr += 1;
        end
        t = (civil_days(yr, mon + 1, 1) - 10957 + longint'(d[32:28]) - 1) * DAY_SECS +
            longint'(clock_secs % DAY_SECS);
        clock_secs = t[31:0];
      end
      rtcca_pkg::REQ_CLEAR: alarm_latched = 1'b0;
      default: ;
    endcase
    days = clock_secs / DAY_SECS;
    tod = clock_secs % DAY_SECS;
    h = tod / 3600;
    if (req != rtcca_pkg::REQ_CLEAR && alm_en && h == alm_hour &&
        (tod / 60) % 60 == alm_min && tod % 60 == 0)
      alarm_latched = 1'b1;
    z = days + 10957 + 719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    m = mp < 10 ? mp + 3 : mp - 9;
    y = yoe + era * 400 + (m <= 2 ? 1 : 0);
    v.full_year = y[11:0];
    v.month = m[3:0];
    v.day = 5'(doy - (153 * mp + 2) / 5 + 1);
    v.weekday = 3'((days + 6) % 7);
    v.shown_hour = mode_12h ? 5'(h == 0 ? 12 : (h > 12 ? h - 12 : h)) : h[4:0];
    v.minute = 6'((tod / 60) % 60);
    v.second = 6'(tod % 60);
    v.is_pm = mode_12h && h >= 12;
    v.alarm_fired = alarm_latched;
    v.seconds_count = clock_secs;
    return v;
  endfunction

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rtcca_pkg::REG_TWELVE_HOUR:  mode_12h = val[0];
      rtcca_pkg::REG_ALARM_ENABLE: alm_en = val[0];
      rtcca_pkg::REG_ALARM_HOUR:   alm_hour = val[4:0];
      default:                     alm_min = val[5:0];
    endcase
  endtask

  // tvalid stays up after a transaction until the next item or an idle cycle drops it
  task automatic send_request(logic [2:0] req, logic [39:0] d);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    expected_views.push_back(advance_clock(req, d));
  endtask

  function automatic logic [39:0] pack_fields(int hr, int mi, int se, int yr, int mo, int dy);
    return {7'd0, 5'(dy), 4'(mo), 7'(yr), 6'(se), 6'(mi), 5'(hr)};
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // result check and output stall
  always @(posedge clk) begin
    view_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[74:0];
        if (expected_views.size() == 0) begin
          $error("result with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          want = expected_views.pop_front();
          if (got.full_year != want.full_year) begin
            $error("full_year exp %0d got %0d", want.full_year, got.full_year); errors++; end
          if (got.month != want.month) begin
            $error("month exp %0d got %0d", want.month, got.month); errors++; end
          if (got.day != want.day) begin
            $error("day exp %0d got %0d", want.day, got.day); errors++; end
          if (got.weekday != want.weekday) begin
            $error("weekday exp %0d got %0d", want.weekday, got.weekday); errors++; end
          if (got.shown_hour != want.shown_hour) begin
            $error("shown_hour exp %0d got %0d", want.shown_hour, got.shown_hour); errors++; end
          if (got.minute != want.minute) begin
            $error("minute exp %0d got %0d", want.minute, got.minute); errors++; end
          if (got.second != want.second) begin
            $error("second exp %0d got %0d", want.second, got.second); errors++; end
          if (got.is_pm != want.is_pm) begin
            $error("is_pm exp %0d got %0d", want.is_pm, got.is_pm); errors++; end
          if (got.alarm_fired != want.alarm_fired) begin
            $error("alarm_fired exp %0d got %0d", want.alarm_fired, got.alarm_fired); errors++; end
          if (got.seconds_count != want.seconds_count) begin
            $error("seconds_count exp %0d got %0d", want.seconds_count, got.seconds_count);
            errors++;
          end
        end
      end
      m_tready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("seconds_counter_calendar_alarm_top test failed");
      $finish;
    end
  end

  task automatic test_registers();
    apb_write(rtcca_pkg::REG_TWELVE_HOUR, 32'd1);
    apb_write(rtcca_pkg::REG_ALARM_ENABLE, 32'd1);
    apb_write(rtcca_pkg::REG_ALARM_HOUR, 32'd0);
    apb_write(rtcca_pkg::REG_ALARM_MINUTE, 32'd0);
  endtask

  task automatic test_directed();
    // alarm at midnight after reset count 0 via read
    send_request(rtcca_pkg::REQ_READ, '0);
    send_request(rtcca_pkg::REQ_CLEAR, '0);
    send_request(rtcca_pkg::REQ_TICK, '0);
    send_request(rtcca_pkg::REQ_SET_TIME, pack_fields(23, 59, 59, 0, 1, 1));
    send_request(rtcca_pkg::REQ_TICK, '0);
    send_request(rtcca_pkg::REQ_SET_TIME, pack_fields(31, 63, 63, 0, 1, 1));
    send_request(rtcca_pkg::REQ_SET_TIME, pack_fields(12, 0, 0, 0, 1, 1));
    send_request(rtcca_pkg::REQ_SET_DATE, pack_fields(0, 0, 0, 0, 0, 0));
    send_request(rtcca_pkg::REQ_SET_DATE, pack_fields(0, 0, 0, 24, 2, 29));
    send_request(rtcca_pkg::REQ_SET_DATE, pack_fields(0, 0, 0, 127, 15, 31));
    send_request(rtcca_pkg::REQ_SET_DATE, pack_fields(0, 0, 0, 99, 12, 31));
    send_request(rtcca_pkg::REQ_SET_DATE, pack_fields(0, 0, 0, 100, 2, 29));
    // date 2036-02-07 and time 06:28:15, then one tick
    send_request(rtcca_pkg::REQ_SET_DATE, pack_fields(0, 0, 0, 36, 2, 7));
    send_request(rtcca_pkg::REQ_SET_TIME, pack_fields(6, 28, 15, 0, 1, 1));
    send_request(rtcca_pkg::REQ_TICK, '0);
    send_request(3'd5, '1);
    send_request(3'd6, '0);
    send_request(3'd7, '1);
    send_request(rtcca_pkg::REQ_CLEAR, '1);
    wait_drained();
    apb_write(rtcca_pkg::REG_TWELVE_HOUR, 32'd0);
    apb_write(rtcca_pkg::REG_ALARM_HOUR, 32'd31);
    apb_write(rtcca_pkg::REG_ALARM_MINUTE, 32'd63);
    send_request(rtcca_pkg::REQ_SET_TIME, pack_fields(31, 63, 0, 0, 1, 1));
    send_request(rtcca_pkg::REQ_READ, '0);
    wait_drained();
  endtask

  task automatic random_item();
    int r;
    logic [39:0] d;
    r = $urandom_range(99);
    d = {7'd0, 33'({$urandom, $urandom})};
    if (r < 4) begin
      // sometimes land right before the alarm minute
      d[4:0] = alm_hour;
      d[10:5] = alm_min - 6'd1;
      d[16:11] = 6'd58 + 6'($urandom_range(1));
      send_request(rtcca_pkg::REQ_SET_TIME, d);
    end else if (r < 50) send_request(rtcca_pkg::REQ_TICK, d);
    else if (r < 62) send_request(rtcca_pkg::REQ_READ, d);
    else if (r < 74) send_request(rtcca_pkg::REQ_SET_TIME, d);
    else if (r < 86) send_request(rtcca_pkg::REQ_SET_DATE, d);
    else if (r < 94) send_request(rtcca_pkg::REQ_CLEAR, d);
    else send_request(3'(5 + $urandom_range(2)), d);
  endtask

  task automatic test_random_phase(int n, int gap, int stall);
    send_gap_pct = gap;
    recv_stall_pct = stall;
    apb_write(rtcca_pkg::REG_TWELVE_HOUR, $urandom);
    apb_write(rtcca_pkg::REG_ALARM_ENABLE, $urandom_range(3) != 0);
    apb_write(rtcca_pkg::REG_ALARM_HOUR, $urandom_range(23));
    apb_write(rtcca_pkg::REG_ALARM_MINUTE, $urandom_range(59));
    repeat (n) random_item();
    wait_drained();
  endtask

  task automatic test_backpressure();
    int cnt;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        cnt = 0;
        while (cnt < 2000) begin
          @(posedge clk);
          cnt++;
        end
        hold_off = 1'b0;
      end
      repeat (10) random_item();
    join
    wait_drained();
  endtask

  initial begin
    clock_secs = '0;
    alarm_latched = 1'b0;
    mode_12h = 1'b0;
    alm_en = 1'b0;
    alm_hour = '0;
    alm_min = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_registers();
    test_directed();
    test_random_phase(RANDOM_ITEMS / 3, 12, 77);
    test_random_phase(RANDOM_ITEMS / 3, 77, 12);
    test_random_phase(RANDOM_ITEMS / 3, 0, 0);
    test_backpressure();
    if (errors == 0) $display("seconds_counter_calendar_alarm_top test passed");
    else $display("seconds_counter_calendar_alarm_top test failed");
    $finish;
  end

endmodule
